>>> hw/rtl/ces_pkg.sv
// Package for the CIGAR error statistics counter: counter sizes, item kinds,
// CIGAR op codes, transition counter indexes, base decoding and the update record.
// Depends on nothing; ces_front, ces_count and the top level import it.
package ces_pkg;

  localparam int unsigned COUNTER_BITS = 32;
  localparam int unsigned INDEL_BINS = 20;
  localparam int unsigned EMIT_COUNT = 16;
  localparam int unsigned TRANS_COUNT = 9;
  localparam int unsigned TRANS_BASE = 16;
  localparam int unsigned INDEL_BASE = TRANS_BASE + TRANS_COUNT;
  localparam int unsigned INDEL_COUNT = 2 * INDEL_BINS;
  localparam int unsigned INDEL_AW = $clog2(INDEL_COUNT);
  localparam int unsigned SELF_LOOP_LIMIT = 10;

  localparam int unsigned OP_W = 4;
  localparam int unsigned LEN_W = 28;
  localparam int unsigned BASE_W = 8;
  localparam int unsigned IDX_W = 7;
  localparam int unsigned EMIT_AW = 4;
  localparam int unsigned TRANS_AW = 4;

  localparam int unsigned IN_DATA_W = 56;
  localparam int unsigned IN_USER_W = 2;
  localparam int unsigned OUT_DATA_W = 40;

  typedef logic [COUNTER_BITS-1:0] cnt_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_CIGAR = 2'd1,
    KIND_PAIR  = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  localparam logic [OP_W-1:0] OP_M = 4'd0;
  localparam logic [OP_W-1:0] OP_I = 4'd1;
  localparam logic [OP_W-1:0] OP_D = 4'd2;
  localparam logic [OP_W-1:0] OP_EQ = 4'd7;
  localparam logic [OP_W-1:0] OP_X = 4'd8;
  localparam logic [OP_W-1:0] OP_NONE = 4'd15;

  localparam logic [TRANS_AW-1:0] TR_MM = 4'd0;
  localparam logic [TRANS_AW-1:0] TR_MI = 4'd1;
  localparam logic [TRANS_AW-1:0] TR_MD = 4'd2;
  localparam logic [TRANS_AW-1:0] TR_IM = 4'd3;
  localparam logic [TRANS_AW-1:0] TR_II = 4'd4;
  localparam logic [TRANS_AW-1:0] TR_DM = 4'd6;
  localparam logic [TRANS_AW-1:0] TR_DD = 4'd8;

  typedef struct packed {
    logic                  emit_en;
    logic [EMIT_AW-1:0]    emit_idx;
    logic                  tone_en;
    logic [TRANS_AW-1:0]   tone_idx;
    logic                  tadd_en;
    logic [TRANS_AW-1:0]   tadd_idx;
    cnt_t                  loops;
    logic                  ind_en;
    logic [INDEL_AW-1:0]   ind_addr;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_idx;
  } upd_t;

  // Returns 1 to 4 for A, C, G, T of either case and 0 for any other byte.
  function automatic logic [2:0] base_code(input logic [BASE_W-1:0] b);
    logic [2:0] code;
    code = 3'd0;
    unique case (b)
      8'h41, 8'h61: code = 3'd1;
      8'h43, 8'h63: code = 3'd2;
      8'h47, 8'h67: code = 3'd3;
      8'h54, 8'h74: code = 3'd4;
      default:      code = 3'd0;
    endcase
    return code;
  endfunction

  function automatic logic is_match_op(input logic [OP_W-1:0] op);
    return (op == OP_M) || (op == OP_EQ) || (op == OP_X);
  endfunction

endpackage

>>> hw/rtl/ces_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module ces_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 40,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ces_front.sv
// Input register, strand and last-op state, and decode of one request into an update record.
// Depends on ces_pkg.
module ces_front import ces_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IN_DATA_W-1:0] in_data_i,
  input  logic [IN_USER_W-1:0] in_user_i,
  output logic                 upd_valid_o,
  input  logic                 upd_ready_i,
  output upd_t                 upd_o
);

  logic                 v_q;
  kind_e                kind_q;
  logic [OP_W-1:0]      op_q;
  logic [LEN_W-1:0]     len_q;
  logic                 rev_q;
  logic [BASE_W-1:0]    ref_q;
  logic [BASE_W-1:0]    rd_q;
  logic [IDX_W-1:0]     idx_q;
  logic [OP_W-1:0]      last_op_q, last_op_d;
  logic                 strand_q, strand_d;
  logic                 fire;
  logic [2:0]           r_code, q_code;
  logic [1:0]           r_sel, q_sel;
  logic                 last_match;
  logic                 in_range;
  logic [IDX_W-1:0]     rel_idx;

  assign in_ready_o = !v_q || upd_ready_i;
  assign fire = v_q && upd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
      last_op_q <= OP_NONE;
      strand_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v_q <= in_valid_i;
      end
      last_op_q <= last_op_d;
      strand_q <= strand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q <= kind_e'(in_user_i);
      op_q <= in_data_i[3:0];
      len_q <= in_data_i[31:4];
      rev_q <= in_data_i[32];
      ref_q <= in_data_i[40:33];
      rd_q <= in_data_i[48:41];
      idx_q <= in_data_i[55:49];
    end
  end

  always_comb begin
    last_op_d = last_op_q;
    strand_d = strand_q;
    if (fire) begin
      unique case (kind_q)
        KIND_START: begin
          strand_d = rev_q;
          last_op_d = OP_NONE;
        end
        KIND_CIGAR: last_op_d = op_q;
        KIND_PAIR, KIND_READ: ;
        default: ;
      endcase
    end
  end

  assign r_code = base_code(ref_q);
  assign q_code = base_code(rd_q);
  assign r_sel = 2'(r_code - 3'd1) ^ {2{strand_q}};
  assign q_sel = 2'(q_code - 3'd1) ^ {2{strand_q}};
  assign last_match = is_match_op(last_op_q);
  assign rel_idx = idx_q - IDX_W'(INDEL_BASE);
  assign in_range = (idx_q >= IDX_W'(INDEL_BASE))
                    && (idx_q < IDX_W'(INDEL_BASE + INDEL_COUNT));

  always_comb begin
    upd_o = '0;
    upd_o.loops = cnt_t'(len_q) - cnt_t'(1);
    upd_o.rd_idx = idx_q;
    unique case (kind_q)
      KIND_CIGAR: begin
        if (is_match_op(op_q)) begin
          upd_o.tone_en = (last_op_q == OP_I) || (last_op_q == OP_D);
          upd_o.tone_idx = (last_op_q == OP_I) ? TR_IM : TR_DM;
          upd_o.ind_en = upd_o.tone_en;
          upd_o.ind_addr = (last_op_q == OP_I) ? INDEL_AW'(INDEL_BINS) : '0;
          upd_o.tadd_en = 1'b1;
          upd_o.tadd_idx = TR_MM;
        end else if (op_q == OP_D) begin
          upd_o.tone_en = last_match;
          upd_o.tone_idx = TR_MD;
          upd_o.tadd_en = len_q < LEN_W'(SELF_LOOP_LIMIT);
          upd_o.tadd_idx = TR_DD;
          upd_o.ind_en = len_q < LEN_W'(INDEL_BINS);
          upd_o.ind_addr = INDEL_AW'(len_q);
        end else if (op_q == OP_I) begin
          upd_o.tone_en = last_match;
          upd_o.tone_idx = TR_MI;
          upd_o.tadd_en = len_q < LEN_W'(SELF_LOOP_LIMIT);
          upd_o.tadd_idx = TR_II;
          upd_o.ind_en = len_q < LEN_W'(INDEL_BINS);
          upd_o.ind_addr = INDEL_AW'(len_q) + INDEL_AW'(INDEL_BINS);
        end
      end
      KIND_PAIR: begin
        upd_o.emit_en = (r_code != 3'd0) && (q_code != 3'd0);
        upd_o.emit_idx = {r_sel, q_sel};
      end
      KIND_READ: begin
        upd_o.rd_en = 1'b1;
        upd_o.ind_addr = in_range ? INDEL_AW'(rel_idx) : '0;
      end
      KIND_START: ;
      default: ;
    endcase
  end

  assign upd_valid_o = v_q;

endmodule

>>> hw/rtl/ces_count.sv
// Update stage: emission and transition counters in flip-flops, indel length counters
// in a RAM with per-bin valid flags, and the result register. Depends on ces_pkg, ces_ram.
module ces_count import ces_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           upd_valid_i,
  output logic           upd_ready_o,
  input  upd_t           upd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cnt_t           out_value_o,
  output logic [IDX_W-1:0] out_echo_o
);

  logic                s1_v_q;
  upd_t                s1_q;
  logic                hit_q, hit_d;
  cnt_t                fwd_q;
  logic                bin_vld_q;
  logic [INDEL_COUNT-1:0] vld_q;
  cnt_t                emit_q [EMIT_COUNT];
  cnt_t                trans_q [TRANS_COUNT];
  logic                out_v_q;
  cnt_t                out_val_q, out_val_d;
  logic [IDX_W-1:0]    out_echo_q;
  logic                out_rdy, s1_adv, fire;
  logic                wr_en;
  cnt_t                rdata, ind_cur, wr_data;
  logic [IDX_W-1:0]    trans_rel;

  assign out_rdy = !out_v_q || out_ready_i;
  assign s1_adv = !s1_v_q || out_rdy;
  assign upd_ready_o = s1_adv;
  assign fire = s1_v_q && out_rdy;
  assign wr_en = fire && s1_q.ind_en;
  assign hit_d = wr_en && (s1_q.ind_addr == upd_i.ind_addr);

  ces_ram #(
    .WIDTH (COUNTER_BITS),
    .DEPTH (INDEL_COUNT)
  ) u_ind_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_q.ind_addr),
    .wdata_i (wr_data),
    .re_i    (s1_adv),
    .raddr_i (upd_i.ind_addr),
    .rdata_o (rdata)
  );

  assign ind_cur = hit_q ? fwd_q : (bin_vld_q ? rdata : '0);
  assign wr_data = ind_cur + cnt_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      out_v_q <= 1'b0;
      vld_q <= '0;
      for (int i = 0; i < EMIT_COUNT; i++) begin
        emit_q[i] <= '0;
      end
      for (int i = 0; i < TRANS_COUNT; i++) begin
        trans_q[i] <= '0;
      end
    end else begin
      if (s1_adv) begin
        s1_v_q <= upd_valid_i;
      end
      if (out_rdy) begin
        out_v_q <= fire && s1_q.rd_en;
      end
      if (wr_en) begin
        vld_q[s1_q.ind_addr] <= 1'b1;
      end
      if (fire && s1_q.emit_en) begin
        emit_q[s1_q.emit_idx] <= emit_q[s1_q.emit_idx] + cnt_t'(1);
      end
      if (fire) begin
        for (int i = 0; i < TRANS_COUNT; i++) begin
          if (s1_q.tone_en && (s1_q.tone_idx == TRANS_AW'(i))) begin
            trans_q[i] <= trans_q[i] + cnt_t'(1);
          end else if (s1_q.tadd_en && (s1_q.tadd_idx == TRANS_AW'(i))) begin
            trans_q[i] <= trans_q[i] + s1_q.loops;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_q <= upd_i;
      hit_q <= hit_d;
      fwd_q <= wr_data;
      bin_vld_q <= vld_q[upd_i.ind_addr];
    end
    if (out_rdy) begin
      out_val_q <= out_val_d;
      out_echo_q <= s1_q.rd_idx;
    end
  end

  assign trans_rel = s1_q.rd_idx - IDX_W'(TRANS_BASE);

  always_comb begin
    if (s1_q.rd_idx < IDX_W'(EMIT_COUNT)) begin
      out_val_d = emit_q[s1_q.rd_idx[EMIT_AW-1:0]];
    end else if (s1_q.rd_idx < IDX_W'(INDEL_BASE)) begin
      out_val_d = trans_q[trans_rel[TRANS_AW-1:0]];
    end else if (s1_q.rd_idx < IDX_W'(INDEL_BASE + INDEL_COUNT)) begin
      out_val_d = ind_cur;
    end else begin
      out_val_d = '0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_value_o = out_val_q;
  assign out_echo_o = out_echo_q;

endmodule

>>> hw/rtl/cigar_error_statistics_counter_top.sv
// Top level of the CIGAR error statistics counter: stream ports, decode front and counter stage.
// Depends on ces_pkg, ces_front, ces_count (and ces_ram below it).
// One request is accepted every clock cycle unless the master side stalls; a counter read
// passes the input, update stage and result registers to the master side, and a stalled
// result holds the input side only once both internal stages are full.
// Reset clears every counter at once (indel bins through per-bin valid flags), sets the
// last operation to none and the strand to forward; requests are taken straight after reset.
module cigar_error_statistics_counter_top import ces_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // cigar_op[3:0], op_length[31:4], reverse_strand[32], ref_base[40:33],
  // read_base[48:41], counter_index[55:49]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // kind[1:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // counter_value[31:0], counter_echo[38:32], zero pad[39]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic             upd_valid, upd_ready;
  upd_t             upd;
  cnt_t             value;
  logic [IDX_W-1:0] echo;

  ces_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .upd_valid_o (upd_valid),
    .upd_ready_i (upd_ready),
    .upd_o       (upd)
  );

  ces_count u_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_valid_i (upd_valid),
    .upd_ready_o (upd_ready),
    .upd_i       (upd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_value_o (value),
    .out_echo_o  (echo)
  );

  assign m_axis_tdata_o = {1'b0, echo, value};

endmodule
